[sv/spg_pkg.sv]
// Package for the shortest path to goal search block.
// Holds sizes, item structs, opcodes and the shared arithmetic types.
// No dependencies; the ALU, the top module and the testbench import it.
package spg_pkg;

    // Graph size and edge cost width
    localparam int VERTEX_COUNT = 16;
    localparam int COST_WIDTH   = 16;

    // Derived sizes
    localparam int VW         = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam int EDGE_SLOTS = VERTEX_COUNT * VERTEX_COUNT;
    localparam int SLOT_W     = $clog2(EDGE_SLOTS);
    localparam int DIST_W     = 24;
    localparam int SUM_W      = ((DIST_W > COST_WIDTH) ? DIST_W : COST_WIDTH) + 1;

    // Opcodes
    localparam logic [1:0] OP_EDGE   = 2'd0;
    localparam logic [1:0] OP_GOAL   = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    typedef logic [VW-1:0]         t_vidx;
    typedef logic [SLOT_W-1:0]     t_slot;
    typedef logic [DIST_W-1:0]     t_dist;
    typedef logic [COST_WIDTH-1:0] t_cost;

    localparam t_dist DIST_MAX = {DIST_W{1'b1}};

    // Input item
    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  src_vertex;
        logic [3:0]  dst_vertex;
        logic [15:0] edge_cost;
        logic        mark;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic        found;
        logic [3:0]  goal_vertex;
        logic [23:0] path_cost;
    } t_out_item;

    // Shared add/compare unit: sum = sat(base + addend), lt = sum < limit
    typedef struct packed {
        t_dist base;
        t_cost addend;
        t_dist limit;
    } t_alu_req;

    typedef struct packed {
        t_dist sum;
        logic  lt;
    } t_alu_rsp;

    // Row-major slot of edge a -> b
    function automatic t_slot slot_of(input t_vidx a, input t_vidx b);
        slot_of = SLOT_W'(SLOT_W'(a) * SLOT_W'(VERTEX_COUNT) + SLOT_W'(b));
    endfunction

endpackage

[sv/spg_ram.sv]
// Generic single write, single read RAM with registered read data.
// No dependencies.
module spg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/spg_alu.sv]
// Shared saturating add and less-than compare used by the scan, relax and final search steps.
// Depends on spg_pkg.
module spg_alu (
    input  spg_pkg::t_alu_req i_req,
    output spg_pkg::t_alu_rsp o_rsp
);
    import spg_pkg::*;

    logic [SUM_W-1:0] wide_sum;

    // Add with saturation at the top of the distance range
    assign wide_sum  = SUM_W'(i_req.base) + SUM_W'(i_req.addend);
    assign o_rsp.sum = (wide_sum > SUM_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(wide_sum);
    assign o_rsp.lt  = (o_rsp.sum < i_req.limit);

endmodule

[sv/shortest_path_to_goal_search.sv]
// Shortest path to goal search: edge/goal writes are accepted one item per cycle while idle.
// A search steps through the vertices in sequence, serialised by the one add/compare unit
// and the one read port of the edge weight memory; input is stalled meanwhile.
// Synchronous active-low reset clears edge presence, goal marks and control;
// the edge weight memory is not cleared and needs no clearing pass.
module shortest_path_to_goal_search (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  spg_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output spg_pkg::t_out_item o_out_item
);
    import spg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SETTLE, S_RD, S_RELAX, S_FINAL, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        VS_UNSEEN, VS_FRONT, VS_SETTLED
    } t_vstat;

    t_state            r_state;
    t_vidx             r_v;
    t_vidx             r_u;
    logic              r_any;
    t_dist             r_best;
    t_dist             r_du;
    t_dist             r_dist [VERTEX_COUNT];
    t_vstat            r_stat [VERTEX_COUNT];
    logic [VERTEX_COUNT-1:0] r_goal;
    logic [EDGE_SLOTS-1:0]   r_present;
    logic              r_edge_on;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic     in_accept;
    t_vidx    in_src;
    t_vidx    in_dst;
    logic     src_ok;
    logic     dst_ok;
    t_slot    wr_slot;
    t_slot    rd_slot;
    logic     ram_we;
    t_cost    ram_rdata;
    logic     last_v;
    logic     out_free;
    t_alu_req alu_req;
    t_alu_rsp alu_rsp;
    logic     scan_take;
    logic     final_take;
    logic     relax_take;

    // Input decode
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign in_src     = VW'(i_in_item.src_vertex);
    assign in_dst     = VW'(i_in_item.dst_vertex);
    assign src_ok     = (32'(i_in_item.src_vertex) < VERTEX_COUNT);
    assign dst_ok     = (32'(i_in_item.dst_vertex) < VERTEX_COUNT);
    assign wr_slot    = slot_of(in_src, in_dst);
    assign rd_slot    = slot_of(r_u, r_v);
    assign ram_we     = in_accept && (i_in_item.opcode == OP_EDGE) && src_ok && dst_ok
                        && i_in_item.mark;

    // Edge weight memory
    spg_ram #(
        .WIDTH(COST_WIDTH),
        .DEPTH(EDGE_SLOTS)
    ) u_weights (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(wr_slot),
        .i_wdata(COST_WIDTH'(i_in_item.edge_cost)),
        .i_raddr(rd_slot),
        .o_rdata(ram_rdata)
    );

    // Shared unit operands: relax adds the edge, scans compare against the best
    always_comb begin
        if (r_state == S_RELAX) begin
            alu_req.base   = r_du;
            alu_req.addend = ram_rdata;
            alu_req.limit  = r_dist[r_v];
        end else begin
            alu_req.base   = r_dist[r_v];
            alu_req.addend = '0;
            alu_req.limit  = r_best;
        end
    end

    spg_alu u_alu (
        .i_req(alu_req),
        .o_rsp(alu_rsp)
    );

    // Per-step decisions
    assign last_v     = (r_v == VW'(VERTEX_COUNT - 1));
    assign out_free   = !r_out_valid || !i_out_stall;
    assign scan_take  = (r_stat[r_v] == VS_FRONT) && (!r_any || alu_rsp.lt);
    assign final_take = (r_stat[r_v] == VS_SETTLED) && r_goal[r_v] && (!r_any || alu_rsp.lt);
    assign relax_take = r_edge_on && (r_stat[r_v] != VS_SETTLED)
                        && ((r_stat[r_v] == VS_UNSEEN) || alu_rsp.lt);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_v         <= '0;
            r_u         <= '0;
            r_any       <= 1'b0;
            r_goal      <= '0;
            r_present   <= '0;
            r_edge_on   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < VERTEX_COUNT; i++) begin
                r_stat[i] <= VS_UNSEEN;
            end
        end else begin
            // Drop a taken result unless a new one is loaded in its place
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        case (i_in_item.opcode)
                            OP_EDGE: begin
                                if (src_ok && dst_ok) begin
                                    r_present[wr_slot] <= i_in_item.mark;
                                end
                            end
                            OP_GOAL: begin
                                if (src_ok) begin
                                    r_goal[in_src] <= i_in_item.mark;
                                end
                            end
                            OP_SEARCH: begin
                                r_v   <= '0;
                                r_any <= 1'b0;
                                if (src_ok) begin
                                    for (int i = 0; i < VERTEX_COUNT; i++) begin
                                        r_stat[i] <= (VW'(i) == in_src) ? VS_FRONT
                                                                        : VS_UNSEEN;
                                    end
                                    r_dist[in_src] <= '0;
                                    r_state        <= S_SCAN;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                // Find the cheapest frontier vertex, lowest number on ties
                S_SCAN: begin
                    if (scan_take) begin
                        r_u    <= r_v;
                        r_best <= r_dist[r_v];
                        r_any  <= 1'b1;
                    end
                    if (last_v) begin
                        r_state <= S_SETTLE;
                    end else begin
                        r_v <= r_v + VW'(1);
                    end
                end
                S_SETTLE: begin
                    r_v <= '0;
                    if (!r_any) begin
                        r_state <= S_FINAL;
                    end else begin
                        r_stat[r_u] <= VS_SETTLED;
                        r_du        <= r_best;
                        r_state     <= S_RD;
                    end
                end
                // Weight read issued from r_u, r_v; presence bit registered alongside
                S_RD: begin
                    r_edge_on <= r_present[rd_slot];
                    r_state   <= S_RELAX;
                end
                S_RELAX: begin
                    if (relax_take) begin
                        r_dist[r_v] <= alu_rsp.sum;
                        r_stat[r_v] <= VS_FRONT;
                    end
                    if (last_v) begin
                        r_v     <= '0;
                        r_any   <= 1'b0;
                        r_state <= S_SCAN;
                    end else begin
                        r_v     <= r_v + VW'(1);
                        r_state <= S_RD;
                    end
                end
                // Pick the cheapest settled goal
                S_FINAL: begin
                    if (final_take) begin
                        r_u    <= r_v;
                        r_best <= r_dist[r_v];
                        r_any  <= 1'b1;
                    end
                    if (last_v) begin
                        r_state <= S_DONE;
                    end else begin
                        r_v <= r_v + VW'(1);
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid           <= 1'b1;
                        r_out_item.found       <= r_any;
                        r_out_item.goal_vertex <= r_any ? 4'(r_u) : 4'd0;
                        r_out_item.path_cost   <= r_any ? r_best : '0;
                        r_state                <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // A search item always leaves idle
    a_search_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && (i_in_item.opcode == OP_SEARCH) |=> (r_state != S_IDLE))
        else $error("search accepted without leaving idle");

    // The vertex being expanded is settled and keeps its distance
    a_relax_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RELAX) |-> (r_stat[r_u] == VS_SETTLED) && (r_dist[r_u] == r_du))
        else $error("expanded vertex not settled or its distance moved");

    // A result with no goal carries zero fields
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.found |->
            (o_out_item.goal_vertex == 4'd0) && (o_out_item.path_cost == '0))
        else $error("not-found result with nonzero fields");

    // A result is only loaded into a free or draining output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && r_out_valid && i_out_stall |=> (r_state == S_DONE))
        else $error("result loaded over a stalled result");

endmodule

[test/tb.sv]
// Self-checking testbench for shortest_path_to_goal_search.
// Keeps its own graph copy and nearest-goal search to predict each search result.
// Depends on spg_pkg for the item structs, opcodes and sizes.
module tb;
    import spg_pkg::*;

    // Opcode the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 1100;
    localparam int HOLD_AT      = 60;
    localparam int HOLD_CYCLES  = 600;
    // Longest search plus a margin, for the quiet stretch at the end
    localparam int DRAIN_CYCLES = 3 * VERTEX_COUNT * VERTEX_COUNT + 3 * VERTEX_COUNT + 16;

    typedef enum logic [1:0] {UNSEEN, FRONTIER, SETTLED} t_vstat;

    // One row of the directed table; exp_* is used only when typed is set
    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  src;
        logic [3:0]  dst;
        logic [15:0] cost;
        logic        mark;
        logic        typed;
        logic        exp_found;
        logic [3:0]  exp_goal;
        logic [23:0] exp_cost;
    } t_row;

    localparam int DIRECTED_ROWS = 24;
    localparam t_row DIRECTED [DIRECTED_ROWS] = '{
        // empty graph: nothing found, from either end of the vertex range
        '{OP_SEARCH, 4'd0,  4'd0,  16'h0000, 1'b0, 1'b1, 1'b0, 4'd0,  24'd0},
        '{OP_SEARCH, 4'd15, 4'd15, 16'hFFFF, 1'b1, 1'b1, 1'b0, 4'd0,  24'd0},
        // start vertex is itself a goal
        '{OP_GOAL,   4'd5,  4'd0,  16'h0000, 1'b1, 1'b0, 1'b0, 4'd0,  24'd0},
        '{OP_SEARCH, 4'd5,  4'd0,  16'h0000, 1'b0, 1'b1, 1'b1, 4'd5,  24'd0},
        // single edge of maximum cost
        '{OP_EDGE,   4'd0,  4'd5,  16'hFFFF, 1'b1, 1'b0, 1'b0, 4'd0,  24'd0},
        '{OP_SEARCH, 4'd0,  4'd0,  16'h0000, 1'b0, 1'b1, 1'b1, 4'd5,  24'd65535},
        // cheaper two-hop path through a zero-cost edge
        '{OP_EDGE,   4'd0,  4'd1,  16'h0000, 1'b1, 1'b0, 1'b0, 4'd0,  24'd0},
        '{OP_EDGE,   4'd1,  4'd5,  16'd100,  1'b1, 1'b0, 1'b0, 4'd0,  24'd0},
        '{OP_SEARCH, 4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 1'b0, 4'd0,  24'd0},
        // tie in cost between goals 5 and 15
        '{OP_GOAL,   4'd15, 4'd0,  16'h0000, 1'b1, 1'b0, 1'b0, 4'd0,  24'd0},
        '{OP_EDGE,   4'd1,  4'd15, 16'd100,  1'b1, 1'b0, 1'b0, 4'd0,  24'd0},
        '{OP_SEARCH, 4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 1'b0, 4'd0,  24'd0},
        // unused opcode with every bit set
        '{OP_UNUSED, 4'd15, 4'd15, 16'hFFFF, 1'b1, 1'b0, 1'b0, 4'd0,  24'd0},
        // edge 15 -> 0 is set; edge clears keep the weight but drop the edge
        '{OP_EDGE,   4'd15, 4'd0,  16'h8000, 1'b1, 1'b0, 1'b0, 4'd0,  24'd0},
        '{OP_EDGE,   4'd0,  4'd5,  16'h1234, 1'b0, 1'b0, 1'b0, 4'd0,  24'd0},
        '{OP_SEARCH, 4'd15, 4'd0,  16'h0000, 1'b1, 1'b0, 1'b0, 4'd0,  24'd0},
        '{OP_EDGE,   4'd1,  4'd5,  16'h0000, 1'b0, 1'b0, 1'b0, 4'd0,  24'd0},
        '{OP_SEARCH, 4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 1'b0, 4'd0,  24'd0},
        // goal clears: no goal left anywhere
        '{OP_GOAL,   4'd5,  4'd0,  16'h0000, 1'b0, 1'b0, 1'b0, 4'd0,  24'd0},
        '{OP_GOAL,   4'd15, 4'd0,  16'h0000, 1'b0, 1'b0, 1'b0, 4'd0,  24'd0},
        '{OP_SEARCH, 4'd0,  4'd0,  16'h0000, 1'b0, 1'b1, 1'b0, 4'd0,  24'd0},
        // goal at vertex 0, reached from 15; vertex 5 has no way out
        '{OP_GOAL,   4'd0,  4'd0,  16'h0000, 1'b1, 1'b0, 1'b0, 4'd0,  24'd0},
        '{OP_SEARCH, 4'd15, 4'd0,  16'h0000, 1'b0, 1'b0, 1'b0, 4'd0,  24'd0},
        '{OP_SEARCH, 4'd5,  4'd0,  16'h0000, 1'b0, 1'b1, 1'b0, 4'd0,  24'd0}
    };

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      i_out_stall = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    // Graph as the testbench sees it
    t_cost                   weight_copy  [EDGE_SLOTS];
    bit                      edge_on_copy [EDGE_SLOTS];
    logic [VERTEX_COUNT-1:0] goal_copy    = '0;

    t_out_item predicted_paths [$];
    int        fail_count   = 0;
    int        burst_left   = 0;

    shortest_path_to_goal_search dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        for (int s = 0; s < EDGE_SLOTS; s++) begin
            weight_copy[s]  = '0;
            edge_on_copy[s] = 1'b0;
        end
    end

    // Uniform cost search from start; cheapest settled goal, lowest number on ties
    function automatic t_out_item nearest_goal(input int start);
        t_dist           reach_cost [VERTEX_COUNT];
        t_vstat          stat [VERTEX_COUNT];
        t_out_item       res;
        int              u;
        bit              any;
        longint unsigned sum;
        t_dist           nd;
        res = '0;
        if (start >= VERTEX_COUNT)
            return res;
        for (int v = 0; v < VERTEX_COUNT; v++) begin
            reach_cost[v] = '0;
            stat[v] = UNSEEN;
        end
        stat[start] = FRONTIER;
        do begin
            any = 1'b0;
            u   = 0;
            for (int v = 0; v < VERTEX_COUNT; v++) begin
                if (stat[v] == FRONTIER && (!any || reach_cost[v] < reach_cost[u])) begin
                    u   = v;
                    any = 1'b1;
                end
            end
            if (any) begin
                stat[u] = SETTLED;
                for (int w = 0; w < VERTEX_COUNT; w++) begin
                    if (edge_on_copy[u * VERTEX_COUNT + w] && stat[w] != SETTLED) begin
                        sum = longint'(reach_cost[u])
                              + longint'(weight_copy[u * VERTEX_COUNT + w]);
                        nd  = (sum > DIST_MAX) ? DIST_MAX : t_dist'(sum);
                        if (stat[w] == UNSEEN || nd < reach_cost[w]) begin
                            reach_cost[w] = nd;
                            stat[w] = FRONTIER;
                        end
                    end
                end
            end
        end while (any);
        for (int v = 0; v < VERTEX_COUNT; v++) begin
            if (stat[v] == SETTLED && goal_copy[v]
                && (!res.found || reach_cost[v] < res.path_cost)) begin
                res.found       = 1'b1;
                res.goal_vertex = 4'(v);
                res.path_cost   = reach_cost[v];
            end
        end
        return res;
    endfunction

    // Apply one accepted item to the graph copy; returns 1 when it yields a result
    function automatic bit model_item(input t_in_item it, output t_out_item res);
        int a;
        int b;
        a   = int'(it.src_vertex);
        b   = int'(it.dst_vertex);
        res = '0;
        case (it.opcode)
            OP_EDGE: begin
                if (a < VERTEX_COUNT && b < VERTEX_COUNT) begin
                    if (it.mark)
                        weight_copy[a * VERTEX_COUNT + b] = t_cost'(it.edge_cost);
                    edge_on_copy[a * VERTEX_COUNT + b] = it.mark;
                end
            end
            OP_GOAL: begin
                if (a < VERTEX_COUNT)
                    goal_copy[a] = it.mark;
            end
            OP_SEARCH: begin
                res = nearest_goal(a);
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // Offer one item, hold it until taken, then idle per the burst pattern
    task automatic push_item(input t_in_item it, input bit typed, input t_out_item typed_res);
        t_out_item res;
        int        gap;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        if (model_item(it, res))
            predicted_paths.insert(predicted_paths.size(), typed ? typed_res : res);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if ($urandom_range(0, 15) == 0)
                gap = $urandom_range(20, 40);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    // Random item of the given opcode; edges lean toward chains v -> v+1
    function automatic t_in_item rand_item(input logic [1:0] op);
        t_in_item    it;
        int unsigned pick;
        it.opcode     = op;
        it.src_vertex = 4'($urandom_range(0, 15));
        it.dst_vertex = ($urandom_range(0, 9) < 4) ? it.src_vertex + 4'd1
                                                    : 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 9);
        case (pick)
            0:       it.edge_cost = 16'h0000;
            1:       it.edge_cost = 16'hFFFF;
            2, 3, 4: it.edge_cost = 16'($urandom_range(0, 15));
            5, 6:    it.edge_cost = 16'($urandom_range(0, 255));
            default: it.edge_cost = 16'($urandom);
        endcase
        it.mark = ($urandom_range(0, 99) < ((op == OP_GOAL) ? 45 : 65));
        return it;
    endfunction

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (predicted_paths.size() == 0) begin
            $error("unexpected result: found=%0d goal_vertex=%0d path_cost=%0d",
                   got.found, got.goal_vertex, got.path_cost);
            fail_count++;
        end else begin
            want = predicted_paths.pop_front();
            if (got.found !== want.found) begin
                $error("found: expected %0d, actual %0d", want.found, got.found);
                fail_count++;
            end
            if (got.goal_vertex !== want.goal_vertex) begin
                $error("goal_vertex: expected %0d, actual %0d", want.goal_vertex, got.goal_vertex);
                fail_count++;
            end
            if (got.path_cost !== want.path_cost) begin
                $error("path_cost: expected %0d, actual %0d", want.path_cost, got.path_cost);
                fail_count++;
            end
        end
    endtask

    // Result side: check taken items, stall in changing modes, one long hold-off
    initial begin
        int unsigned mode;
        int          cycle;
        int          hold_left;
        int          results_seen;
        bit          held_once;
        mode         = 0;
        cycle        = 0;
        hold_left    = 0;
        results_seen = 0;
        held_once    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                check_result(o_out_item);
                results_seen++;
            end
            if (!held_once && results_seen >= HOLD_AT) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            cycle++;
            if (cycle % 64 == 0)
                mode = $urandom_range(0, 3);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 1) == 0);
                    2:       i_out_stall <= (cycle % 4 != 0);
                    default: i_out_stall <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Stimulus: reset, directed table, then random episodes
    initial begin
        t_in_item    it;
        t_out_item   typed_res;
        int          counted;
        int          episode;
        int          n;
        int unsigned r;
        logic [3:0]  u;
        counted = 0;
        episode = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIRECTED_ROWS; k++) begin
            it.opcode     = DIRECTED[k].op;
            it.src_vertex = DIRECTED[k].src;
            it.dst_vertex = DIRECTED[k].dst;
            it.edge_cost  = DIRECTED[k].cost;
            it.mark       = DIRECTED[k].mark;
            typed_res.found       = DIRECTED[k].exp_found;
            typed_res.goal_vertex = DIRECTED[k].exp_goal;
            typed_res.path_cost   = DIRECTED[k].exp_cost;
            push_item(it, DIRECTED[k].typed, typed_res);
        end

        typed_res = '0;
        while (counted < RANDOM_ITEMS) begin
            episode++;
            // Now and then thin the graph out so unreachable goals show up
            if (episode % 7 == 0) begin
                u = 4'($urandom_range(0, 15));
                for (int v = 0; v < VERTEX_COUNT; v++) begin
                    if ($urandom_range(0, 1) == 0) begin
                        it = rand_item(OP_GOAL);
                        it.src_vertex = 4'(v);
                    end else begin
                        it = rand_item(OP_EDGE);
                        it.src_vertex = u;
                        it.dst_vertex = 4'(v);
                    end
                    it.mark = 1'b0;
                    push_item(it, 1'b0, typed_res);
                    counted++;
                end
            end
            // Graph edits, then a few searches on the result
            n = $urandom_range(3, 16);
            for (int k = 0; k < n; k++) begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    it = rand_item(OP_EDGE);
                else if (r < 90)
                    it = rand_item(OP_GOAL);
                else if (r < 96)
                    it = rand_item(OP_SEARCH);
                else
                    it = rand_item(OP_UNUSED);
                push_item(it, 1'b0, typed_res);
                if (it.opcode != OP_UNUSED)
                    counted++;
            end
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++) begin
                push_item(rand_item(OP_SEARCH), 1'b0, typed_res);
                counted++;
            end
        end

        // Last item has been taken; withdraw it so it is not offered again
        i_in_valid <= 1'b0;
        while (predicted_paths.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #40000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
